[design/ttrc_pkg.sv]
package ttrc_pkg;

  // Modulus of the recurrence terms.
  localparam logic [15:0] TERM_MOD = 16'hFFFF;

  // Offset added to the first byte of a message to seed the newer term.
  localparam logic [7:0] INIT_OFFSET = 8'd7;

  // Position multipliers for the two coefficients.
  localparam logic [7:0] ALPHA_MUL = 8'd17;
  localparam logic [7:0] BETA_MUL  = 8'd31;

  // One registered request as it waits in the input stage.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } ttrc_item_t;

endpackage

[design/ttrc_input_stage.sv]
module ttrc_input_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  ttrc_pkg::ttrc_item_t  item_in,
  input  logic                  advance,
  output logic                  item_stall,
  output logic                  stage_valid,
  output ttrc_pkg::ttrc_item_t  stage_item
);

  // The stage can only refuse a request while it holds one that cannot move on.
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item_in;
    end
  end

endmodule

[design/ttrc_term_unit.sv]
module ttrc_term_unit (
  input  logic [7:0]  byte_value,
  input  logic [7:0]  position,
  input  logic [15:0] older_term,
  input  logic [15:0] newer_term,
  output logic [15:0] next_term
);

  logic [15:0] alpha_prod;
  logic [15:0] beta_prod;
  logic [7:0]  alpha;
  logic [7:0]  beta;
  logic [8:0]  factor;
  logic [24:0] x_prod;
  logic [24:0] y_prod;
  logic        x_ge_y;
  logic [24:0] diff;
  logic [16:0] fold;
  logic [16:0] fold_red;
  logic [15:0] m;

  // Coefficients keep only the low byte of the position product.
  assign alpha_prod = {8'd0, position} * {8'd0, ttrc_pkg::ALPHA_MUL};
  assign beta_prod  = {8'd0, position} * {8'd0, ttrc_pkg::BETA_MUL};
  assign alpha      = alpha_prod[7:0];
  assign beta       = beta_prod[7:0];

  assign factor = {1'b0, byte_value} + {1'b0, alpha};
  assign x_prod = {16'd0, factor} * {9'd0, newer_term};
  assign y_prod = {17'd0, beta} * {9'd0, older_term};

  assign x_ge_y = x_prod >= y_prod;
  assign diff   = x_ge_y ? (x_prod - y_prod) : (y_prod - x_prod);

  // Since 2^16 = 1 mod 65535, the high bits fold onto the low half; the sum
  // stays below twice the modulus, so one subtraction finishes the reduction.
  assign fold     = {8'd0, diff[24:16]} + {1'b0, diff[15:0]};
  assign fold_red = (fold >= {1'b0, ttrc_pkg::TERM_MOD}) ?
                    (fold - {1'b0, ttrc_pkg::TERM_MOD}) : fold;
  assign m        = fold_red[15:0];

  // A negative difference follows the 64-bit wrap: (1 - m) mod 65535.
  always_comb begin
    if (x_ge_y) begin
      next_term = m;
    end else if (m == 16'd0) begin
      next_term = 16'd1;
    end else if (m == 16'd1) begin
      next_term = 16'd0;
    end else begin
      next_term = ~m + 16'd1;
    end
  end

endmodule

[design/three_term_recurrence_checksum.sv]
// Channel   Handshake                   Payload
// input     item_valid / item_stall     byte_value, first_byte, last_byte
// output    result_valid / result_stall checksum
//
// A request is registered in the input stage, where the next recurrence term
// is formed in one pass and written back to the term registers as the stage
// advances, so one byte is taken in every cycle unless the input stalls.
// A checksum is loaded into the result register when its last byte's request
// leaves the input stage, and it waits there until it is taken.
// Reset is synchronous and clears the terms, the position and both valid flags.
// The input stalls only when the stage holds a last byte while the result
// register is still full and stalled; other bytes keep flowing.
module three_term_recurrence_checksum (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  byte_value,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] checksum
);

  ttrc_pkg::ttrc_item_t item_in;
  ttrc_pkg::ttrc_item_t stage_item;
  logic                 stage_valid;
  logic                 advance;
  logic                 stage_fire;
  logic                 result_free;

  logic [15:0] older_term;
  logic [15:0] newer_term;
  logic [7:0]  position;
  logic [15:0] older_term_next;
  logic [15:0] newer_term_next;
  logic [7:0]  position_next;
  logic [15:0] step_term;

  assign item_in.byte_value = byte_value;
  assign item_in.first_byte = first_byte;
  assign item_in.last_byte  = last_byte;

  // The result register has room when empty or when its request is taken now.
  assign result_free = !result_valid || !result_stall;

  // Only a last byte needs the result register; others always move on.
  assign advance    = !stage_item.last_byte || result_free;
  assign stage_fire = stage_valid && advance;

  ttrc_input_stage u_input_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_in    (item_in),
    .advance    (advance),
    .item_stall (item_stall),
    .stage_valid(stage_valid),
    .stage_item (stage_item)
  );

  ttrc_term_unit u_term_unit (
    .byte_value(stage_item.byte_value),
    .position  (position),
    .older_term(older_term),
    .newer_term(newer_term),
    .next_term (step_term)
  );

  // A first byte restarts the recurrence; any other byte shifts the terms.
  always_comb begin
    if (stage_item.first_byte) begin
      older_term_next = 16'd1;
      newer_term_next = {8'd0, stage_item.byte_value} + {8'd0, ttrc_pkg::INIT_OFFSET};
      position_next   = 8'd1;
    end else begin
      older_term_next = newer_term;
      newer_term_next = step_term;
      position_next   = position + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_term <= 16'd0;
      newer_term <= 16'd0;
      position   <= 8'd0;
    end else if (stage_fire) begin
      older_term <= older_term_next;
      newer_term <= newer_term_next;
      position   <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_fire && stage_item.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_item.last_byte) begin
      checksum <= newer_term_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Every term is reduced, so the all-ones pattern can never be held.
  a_term_reduced: assert property (@(posedge clk) disable iff (rst)
    newer_term != 16'hFFFF)
    else $error("newer term left unreduced");

  // The input only stalls behind a registered byte.
  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> stage_valid)
    else $error("input stalled with an empty stage");

  // A processed last byte presents the term it produced.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    stage_fire && stage_item.last_byte |=> result_valid && checksum == newer_term)
    else $error("last byte did not produce its checksum");

  // A continuing byte advances the position by one, wrapping at 256.
  a_position_step: assert property (@(posedge clk) disable iff (rst)
    stage_fire && !stage_item.first_byte |=> position == $past(position) + 8'd1)
    else $error("position did not advance");
`endif

endmodule
